// ===== hdl/bbcr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbcr_pkg
// Shared types and fixed constants of the box-box collision resolver.
// ----------------------------------------------------------------------------
package bbcr_pkg;

    // Width of the restitution register, unsigned Q1.8
    localparam int REST_BITS = 9;

    // Restitution of one (Q1.8); larger values clamp to this
    localparam logic [REST_BITS-1:0] REST_ONE = 9'd256;

    // Restitution after reset: 0.5
    localparam logic [REST_BITS-1:0] REST_RESET = 9'd128;

    // Round half up before dropping the Q0.8 fraction of the impulse
    localparam int ROUND_HALF  = 128;
    localparam int ROUND_SHIFT = 8;

    // Push axis codes
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

endpackage : bbcr_pkg
`default_nettype wire

// ===== hdl/box_box_collision_resolve.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_box_collision_resolve
// Overlap test, least-overlap push and restitution impulse for one pair of
// axis-aligned boxes per word, saturating signed fixed-point components.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_valid / in_stall carry one word holding both boxes
//   (centre, half size, velocity, each three packed components, x lowest)
//   and the static flag of the first box. Output channel: out_valid /
//   out_stall carry the hit flag, push axis and sign, overlap depth and the
//   corrected position and velocity of the first box. A word moves on a
//   rising edge with valid high and stall low.
//   Throughput: one word per cycle while the receiver does not stall; four
//   register stages (overlap test, axis select, impulse and push, velocity
//   update) lead to out_valid, the first loaded at acceptance.
//   Restitution is written through cfg_write_enable / cfg_write_data only
//   while the block is idle, a rule on the user that the block does not
//   enforce; values above one act as one. Reset empties the pipeline and
//   sets restitution to 0.5. When the receiver stalls the output word holds;
//   each stage keeps its word until the stage after it frees, empty stages
//   still fill, and in_stall rises once the whole pipeline is full.
// ----------------------------------------------------------------------------
module box_box_collision_resolve #(
    parameter int COMPONENT_BITS = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration
    input  wire logic                            cfg_write_enable,
    input  wire logic [bbcr_pkg::REST_BITS-1:0]  cfg_write_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [3*COMPONENT_BITS-1:0]     own_position,
    input  wire logic [3*COMPONENT_BITS-1:0]     own_half_size,
    input  wire logic [3*COMPONENT_BITS-1:0]     own_velocity,
    input  wire logic [3*COMPONENT_BITS-1:0]     other_position,
    input  wire logic [3*COMPONENT_BITS-1:0]     other_half_size,
    input  wire logic [3*COMPONENT_BITS-1:0]     other_velocity,
    input  wire logic                            own_is_static,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 hit,
    output bbcr_pkg::axis_t                      push_axis,
    output logic                                 push_negative,
    output logic [COMPONENT_BITS:0]              overlap_depth,
    output logic [3*COMPONENT_BITS-1:0]          new_position,
    output logic [3*COMPONENT_BITS-1:0]          new_velocity
);

    import bbcr_pkg::*;

    localparam int CB = COMPONENT_BITS;
    // Overlap and intermediate sums need three guard bits over a component
    localparam int W  = CB + 3;

    localparam logic signed [W-1:0] CMAX_W    = $signed({4'b0000, {(CB-1){1'b1}}});
    localparam logic signed [W-1:0] CMIN_W    = $signed({4'b1111, {(CB-1){1'b0}}});
    localparam logic        [W-1:0] DEPTH_MAX = {2'b00, {(CB+1){1'b1}}};

    function automatic logic signed [W-1:0] sext(input logic [CB-1:0] x);
        return $signed({{3{x[CB-1]}}, x});
    endfunction

    function automatic logic signed [W-1:0] zext(input logic [CB-1:0] x);
        return $signed({3'b000, x});
    endfunction

    function automatic logic [CB-1:0] sat(input logic signed [W-1:0] x);
        logic [CB-1:0] r;
        if (x > CMAX_W)
            r = CMAX_W[CB-1:0];
        else if (x < CMIN_W)
            r = CMIN_W[CB-1:0];
        else
            r = x[CB-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Restitution register
    // ------------------------------------------------------------------
    logic [REST_BITS-1:0] restitution_reg;
    logic [REST_BITS-1:0] rest_clamped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            restitution_reg <= REST_RESET;
        else if (cfg_write_enable)
            restitution_reg <= cfg_write_data;
    end

    assign rest_clamped = (restitution_reg > REST_ONE) ? REST_ONE : restitution_reg;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic ready1, ready2, ready3, ready4;

    assign ready4   = !out_valid_reg || !out_stall;
    assign ready3   = !s3_valid_reg  || ready4;
    assign ready2   = !s2_valid_reg  || ready3;
    assign ready1   = !s1_valid_reg  || ready2;
    assign in_stall = !ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
                s1_valid_reg <= in_valid;
            if (ready2)
                s2_valid_reg <= s1_valid_reg;
            if (ready3)
                s3_valid_reg <= s2_valid_reg;
            if (ready4)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: per-axis overlap, hit test, centre order, relative velocity
    // ------------------------------------------------------------------
    logic [2:0][W-1:0]  ovl_next;
    logic [2:0]         axis_hit_next;
    logic [2:0]         neg_next;
    logic [2:0][CB:0]   dvel_next;

    logic               s1_hit_reg;
    logic               s1_static_reg;
    logic [REST_BITS-1:0] s1_e_reg;
    logic [2:0][CB-1:0] s1_pos_reg;
    logic [2:0][CB-1:0] s1_vel_reg;
    logic [2:0][W-1:0]  s1_ovl_reg;
    logic [2:0]         s1_neg_reg;
    logic [2:0][CB:0]   s1_dvel_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic signed [W-1:0] a_ext;
            logic signed [W-1:0] b_ext;
            a_ext = sext(own_position[k*CB +: CB]) + zext(own_half_size[k*CB +: CB])
                  - sext(other_position[k*CB +: CB]) + zext(other_half_size[k*CB +: CB]);
            b_ext = sext(other_position[k*CB +: CB]) + zext(other_half_size[k*CB +: CB])
                  - sext(own_position[k*CB +: CB]) + zext(own_half_size[k*CB +: CB]);
            axis_hit_next[k] = !a_ext[W-1] && !b_ext[W-1];
            ovl_next[k]      = (a_ext < b_ext) ? a_ext : b_ext;
            neg_next[k]      = $signed(own_position[k*CB +: CB])
                             < $signed(other_position[k*CB +: CB]);
            dvel_next[k]     = {own_velocity[k*CB+CB-1], own_velocity[k*CB +: CB]}
                             - {other_velocity[k*CB+CB-1], other_velocity[k*CB +: CB]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            s1_hit_reg    <= &axis_hit_next;
            s1_static_reg <= own_is_static;
            s1_e_reg      <= rest_clamped;
            s1_pos_reg    <= own_position;
            s1_vel_reg    <= own_velocity;
            s1_ovl_reg    <= ovl_next;
            s1_neg_reg    <= neg_next;
            s1_dvel_reg   <= dvel_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: least-overlap axis (ties keep the lower axis), closing speed
    // ------------------------------------------------------------------
    axis_t             sel_axis;
    logic [W-1:0]      sel_m;
    logic              sel_neg;
    logic [CB:0]       sel_dvel;
    logic [CB:0]       sel_s;
    logic [CB:0]       neg_s;
    logic              approach;
    logic [CB-1:0]     sel_ns;

    logic               s2_hit_reg;
    logic               s2_static_reg;
    logic [REST_BITS-1:0] s2_e_reg;
    axis_t              s2_axis_reg;
    logic               s2_neg_reg;
    logic [W-1:0]       s2_m_reg;
    logic [CB-1:0]      s2_ns_reg;
    logic [2:0][CB-1:0] s2_pos_reg;
    logic [2:0][CB-1:0] s2_vel_reg;

    always_comb
    begin
        sel_axis = AXIS_X;
        sel_m    = s1_ovl_reg[0];
        if ($signed(s1_ovl_reg[1]) < $signed(sel_m))
        begin
            sel_axis = AXIS_Y;
            sel_m    = s1_ovl_reg[1];
        end
        if ($signed(s1_ovl_reg[2]) < $signed(sel_m))
        begin
            sel_axis = AXIS_Z;
            sel_m    = s1_ovl_reg[2];
        end
    end

    always_comb
    begin
        unique case (sel_axis)
            AXIS_Y:
            begin
                sel_neg  = s1_neg_reg[1];
                sel_dvel = s1_dvel_reg[1];
            end
            AXIS_Z:
            begin
                sel_neg  = s1_neg_reg[2];
                sel_dvel = s1_dvel_reg[2];
            end
            default:
            begin
                sel_neg  = s1_neg_reg[0];
                sel_dvel = s1_dvel_reg[0];
            end
        endcase
    end

    // Closing speed along the push normal; impulse only while approaching
    assign sel_s    = sel_neg ? (~sel_dvel + 1'b1) : sel_dvel;
    assign neg_s    = ~sel_s + 1'b1;
    assign approach = sel_s[CB] || (sel_s == '0);
    assign sel_ns   = approach ? neg_s[CB-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            s2_hit_reg    <= s1_hit_reg;
            s2_static_reg <= s1_static_reg;
            s2_e_reg      <= s1_e_reg;
            s2_axis_reg   <= s1_hit_reg ? sel_axis : AXIS_X;
            s2_neg_reg    <= s1_hit_reg && sel_neg;
            s2_m_reg      <= sel_m;
            s2_ns_reg     <= sel_ns;
            s2_pos_reg    <= s1_pos_reg;
            s2_vel_reg    <= s1_vel_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: impulse product, depth saturation, position push
    // ------------------------------------------------------------------
    logic [REST_BITS:0]   factor;
    logic [CB+9:0]        prod_next;
    logic [CB:0]          depth_next;
    logic                 apply2;
    logic signed [W-1:0]  half_m;
    logic signed [W-1:0]  pos_step;
    logic [2:0][CB-1:0]   pos_next;

    logic               s3_hit_reg;
    logic               s3_apply_reg;
    axis_t              s3_axis_reg;
    logic               s3_neg_reg;
    logic [CB:0]        s3_depth_reg;
    logic [CB+9:0]      s3_prod_reg;
    logic [2:0][CB-1:0] s3_pos_reg;
    logic [2:0][CB-1:0] s3_vel_reg;

    assign factor    = {1'b0, s2_e_reg} + {1'b0, REST_ONE};
    assign prod_next = (CB+10)'(factor) * (CB+10)'(s2_ns_reg);
    assign apply2    = s2_hit_reg && !s2_static_reg;
    assign half_m    = $signed({1'b0, s2_m_reg[W-1:1]});
    assign pos_step  = s2_neg_reg ? -half_m : half_m;

    always_comb
    begin
        if (!s2_hit_reg)
            depth_next = '0;
        else if (s2_m_reg > DEPTH_MAX)
            depth_next = DEPTH_MAX[CB:0];
        else
            depth_next = s2_m_reg[CB:0];
    end

    always_comb
    begin
        pos_next = s2_pos_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (apply2 && (s2_axis_reg == axis_t'(k)))
                pos_next[k] = sat(sext(s2_pos_reg[k]) + pos_step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            s3_hit_reg   <= s2_hit_reg;
            s3_apply_reg <= apply2;
            s3_axis_reg  <= s2_axis_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_depth_reg <= depth_next;
            s3_prod_reg  <= prod_next;
            s3_pos_reg   <= pos_next;
            s3_vel_reg   <= s2_vel_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: round the impulse, update velocity, output register
    // ------------------------------------------------------------------
    logic [CB+9:0]        rounded;
    logic [CB+1:0]        delta;
    logic signed [W-1:0]  delta_ext;
    logic signed [W-1:0]  vel_step;
    logic [2:0][CB-1:0]   vel_next;

    logic                       out_hit_reg;
    axis_t                      out_axis_reg;
    logic                       out_neg_reg;
    logic [CB:0]                out_depth_reg;
    logic [3*CB-1:0]            out_pos_reg;
    logic [3*CB-1:0]            out_vel_reg;

    assign rounded   = s3_prod_reg + (CB+10)'(ROUND_HALF);
    assign delta     = rounded[CB+9:ROUND_SHIFT];
    assign delta_ext = $signed({1'b0, delta});
    assign vel_step  = s3_neg_reg ? -delta_ext : delta_ext;

    always_comb
    begin
        vel_next = s3_vel_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (s3_apply_reg && (s3_axis_reg == axis_t'(k)))
                vel_next[k] = sat(sext(s3_vel_reg[k]) + vel_step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4)
        begin
            out_hit_reg   <= s3_hit_reg;
            out_axis_reg  <= s3_axis_reg;
            out_neg_reg   <= s3_neg_reg;
            out_depth_reg <= s3_depth_reg;
            out_pos_reg   <= s3_pos_reg;
            out_vel_reg   <= vel_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign push_axis     = out_axis_reg;
    assign push_negative = out_neg_reg;
    assign overlap_depth = out_depth_reg;
    assign new_position  = out_pos_reg;
    assign new_velocity  = out_vel_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Least overlap of a hit is never negative
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_hit_reg |-> !s2_m_reg[W-1])
        else $error("negative overlap on a hit");

    // A miss reports no contact details
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (push_axis == AXIS_X) && !push_negative
                              && (overlap_depth == '0))
        else $error("contact fields set on a miss");

    // Input back-pressure only arises behind a waiting output word
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // A delivered word with nothing behind it leaves the output empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !s3_valid_reg |=> !out_valid)
        else $error("output word repeated");

endmodule : box_box_collision_resolve
`default_nettype wire

// ===== dv/tb_box_box_collision_resolve.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_box_collision_resolve
// Self-checking bench for the box-box collision resolver. Box pairs are
// streamed in under random gaps and back-pressure. A scoreboard works out
// each contact word from its own model of the block and checks the output
// words field by field, in order, across several restitution settings.
// ----------------------------------------------------------------------------
module tb_box_box_collision_resolve;

    import bbcr_pkg::*;

    localparam int CB = 16;                      // bits per component
    localparam int SETTLE_CYCLES = 8;            // drain margin behind the 4-stage pipeline
    localparam int QUIET_LIMIT = 4000;           // cycles with no word moved
    localparam int LONG_HOLD = 300;              // receiver hold-off stretch
    localparam int GAP_PERCENT = 35;

    localparam longint COMP_MAX  = (longint'(1) << (CB - 1)) - 1;
    localparam longint COMP_MIN  = -(longint'(1) << (CB - 1));
    localparam longint DEPTH_MAX = (longint'(1) << (CB + 1)) - 1;

    // One input word: both boxes and the static flag of the first one
    typedef struct packed {
        logic [3*CB-1:0] own_position;
        logic [3*CB-1:0] own_half_size;
        logic [3*CB-1:0] own_velocity;
        logic [3*CB-1:0] other_position;
        logic [3*CB-1:0] other_half_size;
        logic [3*CB-1:0] other_velocity;
        logic            own_is_static;
    } box_pair_t;

    // One output word: the resolved contact
    typedef struct packed {
        logic            hit;
        axis_t           push_axis;
        logic            push_negative;
        logic [CB:0]     overlap_depth;
        logic [3*CB-1:0] new_position;
        logic [3*CB-1:0] new_velocity;
    } contact_t;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the restitution copy and the queue of contacts that
    // the block still owes us.
    // ------------------------------------------------------------------------
    class contact_scoreboard;
        contact_t             pending_contacts[$];
        logic [REST_BITS-1:0] restitution;
        int unsigned          mismatches;

        function new();
            restitution = REST_RESET;
            mismatches  = 0;
        endfunction

        function longint signed_comp(logic [3*CB-1:0] word, int k);
            logic signed [CB-1:0] c;
            c = word[k*CB +: CB];
            return longint'(c);
        endfunction

        function longint unsigned_comp(logic [3*CB-1:0] word, int k);
            logic [CB-1:0] c;
            c = word[k*CB +: CB];
            return longint'(c);
        endfunction

        function logic [3*CB-1:0] pack_clamped(longint c[3]);
            logic [3*CB-1:0] r;
            longint          t;
            int              k;
            for (k = 0; k < 3; k++)
            begin
                t = c[k];
                if (t > COMP_MAX) t = COMP_MAX;
                if (t < COMP_MIN) t = COMP_MIN;
                r[k*CB +: CB] = CB'(t);
            end
            return r;
        endfunction

        // Overlap test, least-overlap push and restitution impulse
        function contact_t resolve_contact(box_pair_t w);
            longint   p[3], h[3], v[3], q[3], g[3], u[3], ov[3];
            longint   a, b, m, s, e, prod, delta, sgn, depth;
            logic     overlap, neg;
            axis_t    ax;
            int       k, ai;
            contact_t r;
            overlap = 1'b1;
            for (k = 0; k < 3; k++)
            begin
                p[k] = signed_comp(w.own_position, k);
                h[k] = unsigned_comp(w.own_half_size, k);
                v[k] = signed_comp(w.own_velocity, k);
                q[k] = signed_comp(w.other_position, k);
                g[k] = unsigned_comp(w.other_half_size, k);
                u[k] = signed_comp(w.other_velocity, k);
                if (p[k] - h[k] > q[k] + g[k] || p[k] + h[k] < q[k] - g[k])
                    overlap = 1'b0;
                a = (p[k] + h[k]) - (q[k] - g[k]);
                b = (q[k] + g[k]) - (p[k] - h[k]);
                ov[k] = (a < b) ? a : b;
            end
            ax    = AXIS_X;
            neg   = 1'b0;
            depth = 0;
            if (overlap)
            begin
                // ties keep the earlier axis: x before y before z
                m = ov[0];
                if (ov[1] < m)
                begin
                    ax = AXIS_Y;
                    m  = ov[1];
                end
                if (ov[2] < m)
                begin
                    ax = AXIS_Z;
                    m  = ov[2];
                end
                ai    = int'(ax);
                neg   = (p[ai] < q[ai]);
                sgn   = neg ? -1 : 1;
                depth = (m > DEPTH_MAX) ? DEPTH_MAX : m;
                if (!w.own_is_static)
                begin
                    s = (v[ai] - u[ai]) * sgn;
                    p[ai] += sgn * (m / 2);
                    // closing or resting contact: bounce with (1 + e)
                    if (s <= 0)
                    begin
                        e     = (restitution > REST_ONE) ? longint'(REST_ONE)
                                                         : longint'(restitution);
                        prod  = (longint'(REST_ONE) + e) * (-s);
                        delta = (prod + ROUND_HALF) >> ROUND_SHIFT;
                        v[ai] += sgn * delta;
                    end
                end
            end
            r.hit           = overlap;
            r.push_axis     = overlap ? ax : AXIS_X;
            r.push_negative = overlap && neg;
            r.overlap_depth = overlap ? (CB+1)'(depth) : '0;
            r.new_position  = pack_clamped(p);
            r.new_velocity  = pack_clamped(v);
            return r;
        endfunction

        function void note_pair(box_pair_t w);
            pending_contacts.push_back(resolve_contact(w));
        endfunction

        function int outstanding();
            return pending_contacts.size();
        endfunction

        function void check_contact(contact_t got);
            contact_t want;
            if (pending_contacts.size() == 0)
            begin
                $error("contact word with nothing pending: %h", got);
                mismatches++;
                return;
            end
            want = pending_contacts.pop_front();
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, got.hit);
                mismatches++;
            end
            if (got.push_axis !== want.push_axis)
            begin
                $error("push_axis: expected %0d, got %0d", want.push_axis, got.push_axis);
                mismatches++;
            end
            if (got.push_negative !== want.push_negative)
            begin
                $error("push_negative: expected %0d, got %0d",
                       want.push_negative, got.push_negative);
                mismatches++;
            end
            if (got.overlap_depth !== want.overlap_depth)
            begin
                $error("overlap_depth: expected %h, got %h",
                       want.overlap_depth, got.overlap_depth);
                mismatches++;
            end
            if (got.new_position !== want.new_position)
            begin
                $error("new_position: expected %h, got %h",
                       want.new_position, got.new_position);
                mismatches++;
            end
            if (got.new_velocity !== want.new_velocity)
            begin
                $error("new_velocity: expected %h, got %h",
                       want.new_velocity, got.new_velocity);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk              = 1'b0;
    logic                 rst_n            = 1'b0;
    logic                 cfg_write_enable = 1'b0;
    logic [REST_BITS-1:0] cfg_write_data   = '0;
    logic                 in_valid         = 1'b0;
    logic                 in_stall;
    logic [3*CB-1:0]      own_position     = '0;
    logic [3*CB-1:0]      own_half_size    = '0;
    logic [3*CB-1:0]      own_velocity     = '0;
    logic [3*CB-1:0]      other_position   = '0;
    logic [3*CB-1:0]      other_half_size  = '0;
    logic [3*CB-1:0]      other_velocity   = '0;
    logic                 own_is_static    = 1'b0;
    logic                 out_valid;
    logic                 out_stall        = 1'b0;
    logic                 hit;
    axis_t                push_axis;
    logic                 push_negative;
    logic [CB:0]          overlap_depth;
    logic [3*CB-1:0]      new_position;
    logic [3*CB-1:0]      new_velocity;

    contact_scoreboard sb;

    // Shared knobs: gapless switches off idling on both sides, rx_hold_req
    // asks the receiver for one long hold-off whose length is its value.
    bit gapless     = 1'b0;
    int rx_hold_req = 0;

    box_box_collision_resolve #(
        .COMPONENT_BITS (CB)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .own_position     (own_position),
        .own_half_size    (own_half_size),
        .own_velocity     (own_velocity),
        .other_position   (other_position),
        .other_half_size  (other_half_size),
        .other_velocity   (other_velocity),
        .own_is_static    (own_is_static),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hit              (hit),
        .push_axis        (push_axis),
        .push_negative    (push_negative),
        .overlap_depth    (overlap_depth),
        .new_position     (new_position),
        .new_velocity     (new_velocity)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Pack three signed integers into one component triple, x lowest
    function automatic logic [3*CB-1:0] trio(int x, int y, int z);
        return {CB'(z), CB'(y), CB'(x)};
    endfunction

    function automatic box_pair_t boxes(logic [3*CB-1:0] op, logic [3*CB-1:0] oh,
                                        logic [3*CB-1:0] ov, logic [3*CB-1:0] qp,
                                        logic [3*CB-1:0] qh, logic [3*CB-1:0] qv,
                                        logic st);
        box_pair_t w;
        w.own_position    = op;
        w.own_half_size   = oh;
        w.own_velocity    = ov;
        w.other_position  = qp;
        w.other_half_size = qh;
        w.other_velocity  = qv;
        w.own_is_static   = st;
        return w;
    endfunction

    // Now and then swap a component for one of the range corners
    function automatic logic [CB-1:0] maybe_corner(logic [CB-1:0] val);
        if ($urandom_range(0, 99) >= 8)
            return val;
        unique case ($urandom_range(0, 4))
            0:       return '0;
            1:       return {1'b0, {(CB-1){1'b1}}};
            2:       return {1'b1, {(CB-1){1'b0}}};
            3:       return '1;
            default: return CB'(1);
        endcase
    endfunction

    // Mostly pairs placed close together so that contacts are common; the
    // rest is raw noise that toggles every bit, top bits of half sizes too.
    function automatic box_pair_t random_pair();
        box_pair_t w;
        int        k, base;
        if ($urandom_range(0, 99) < 15)
        begin
            w.own_position    = (3*CB)'({$urandom, $urandom});
            w.own_half_size   = (3*CB)'({$urandom, $urandom});
            w.own_velocity    = (3*CB)'({$urandom, $urandom});
            w.other_position  = (3*CB)'({$urandom, $urandom});
            w.other_half_size = (3*CB)'({$urandom, $urandom});
            w.other_velocity  = (3*CB)'({$urandom, $urandom});
        end
        else
        begin
            for (k = 0; k < 3; k++)
            begin
                base = int'($urandom_range(0, 60000)) - 30000;
                w.own_position[k*CB +: CB] =
                    maybe_corner(CB'(base + int'($urandom_range(0, 2048)) - 1024));
                w.other_position[k*CB +: CB] =
                    maybe_corner(CB'(base + int'($urandom_range(0, 2048)) - 1024));
                w.own_half_size[k*CB +: CB]   = maybe_corner(CB'($urandom_range(0, 1200)));
                w.other_half_size[k*CB +: CB] = maybe_corner(CB'($urandom_range(0, 1200)));
                w.own_velocity[k*CB +: CB] =
                    maybe_corner(CB'(int'($urandom_range(0, 4096)) - 2048));
                w.other_velocity[k*CB +: CB] =
                    maybe_corner(CB'(int'($urandom_range(0, 4096)) - 2048));
            end
        end
        w.own_is_static = ($urandom_range(0, 3) == 0);
        return w;
    endfunction

    // Offer one word after an optional random gap; return at the edge that
    // takes it. The payload holds while the block stalls.
    task automatic offer_word(box_pair_t w);
        while (!gapless && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        own_position    <= w.own_position;
        own_half_size   <= w.own_half_size;
        own_velocity    <= w.own_velocity;
        other_position  <= w.other_position;
        other_half_size <= w.other_half_size;
        other_velocity  <= w.other_velocity;
        own_is_static   <= w.own_is_static;
        in_valid        <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pair(w);
    endtask

    // Wait until every contact owed has come back, then let the pipe settle
    task automatic wait_drain();
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write restitution while the pipe is empty and keep our copy in step
    task automatic write_restitution(logic [REST_BITS-1:0] value);
        cfg_write_data   <= value;
        cfg_write_enable <= 1'b1;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        sb.restitution = value;
    endtask

    // Hand-picked pairs: separation on each axis, touching, least overlap on
    // each axis, ties, approaching, separating and resting contact, a static
    // box, saturation of position and velocity, and half sizes with the top
    // bit set.
    task automatic run_directed();
        offer_word(boxes('0, '0, '0, '0, '0, '0, 1'b0));
        offer_word(boxes('1, '1, '1, '1, '1, '1, 1'b1));
        offer_word(boxes(trio(0, 0, 0), trio(256, 256, 256), trio(64, 0, 0),
                         trio(1024, 0, 0), trio(256, 256, 256), '0, 1'b0));
        offer_word(boxes(trio(0, 0, 0), trio(256, 256, 256), trio(0, 64, 0),
                         trio(0, -1024, 0), trio(256, 256, 256), '0, 1'b0));
        offer_word(boxes(trio(0, 0, 0), trio(256, 256, 256), trio(0, 0, 64),
                         trio(0, 0, 1024), trio(256, 256, 256), '0, 1'b0));
        offer_word(boxes(trio(1024, 0, 0), trio(256, 256, 256), '0,
                         trio(0, 0, 0), trio(256, 256, 256), '0, 1'b0));
        // touching faces on x while closing in
        offer_word(boxes(trio(0, 0, 0), trio(256, 256, 256), trio(100, 0, 0),
                         trio(512, 0, 0), trio(256, 256, 256), trio(-100, 0, 0), 1'b0));
        offer_word(boxes(trio(0, 0, 0), trio(256, 256, 256), trio(100, 0, 0),
                         trio(512, 0, 0), trio(256, 256, 256), trio(-100, 0, 0), 1'b1));
        offer_word(boxes(trio(0, 0, 0), trio(512, 512, 512), trio(0, 300, 0),
                         trio(0, 700, 0), trio(256, 256, 256), '0, 1'b0));
        // least overlap on z, first separating then closing
        offer_word(boxes(trio(0, 0, -600), trio(512, 512, 512), trio(0, 0, -200),
                         trio(0, 0, 0), trio(256, 256, 256), '0, 1'b0));
        offer_word(boxes(trio(0, 0, -600), trio(512, 512, 512), trio(0, 0, 200),
                         trio(0, 0, 0), trio(256, 256, 256), '0, 1'b0));
        offer_word(boxes(trio(0, 0, 0), trio(256, 256, 256), trio(-40, 30, 0),
                         trio(400, 400, 0), trio(256, 256, 256), '0, 1'b0));
        offer_word(boxes(trio(0, 0, 0), trio(256, 256, 256), trio(0, -30, 30),
                         trio(0, 400, 400), trio(256, 256, 256), '0, 1'b0));
        offer_word(boxes(trio(0, 0, 0), trio(256, 256, 256), trio(7, 7, 7),
                         trio(300, 300, 300), trio(256, 256, 256), '0, 1'b0));
        // equal velocities: resting contact, zero impulse
        offer_word(boxes(trio(0, 0, 0), trio(256, 256, 256), trio(50, 0, 0),
                         trio(512, 0, 0), trio(256, 256, 256), trio(50, 0, 0), 1'b0));
        // push and bounce both clamp at the top of the range
        offer_word(boxes(trio(32767, 0, 0), trio(-1, -1, -1), trio(-32768, 0, 0),
                         trio(0, 0, 0), trio(-1, -1, -1), trio(32767, 0, 0), 1'b0));
        // and at the bottom
        offer_word(boxes(trio(-32768, 0, 0), trio(-1, -1, -1), trio(32767, 0, 0),
                         trio(0, 0, 0), trio(-1, -1, -1), trio(-32768, 0, 0), 1'b0));
        // half size of 0x8000 reads as a large positive extent
        offer_word(boxes(trio(0, 0, 0), trio(-32768, 256, 256), trio(300, 0, 0),
                         trio(20000, 0, 0), trio(256, 256, 256), trio(-300, 0, 0), 1'b0));
        // zero-size boxes on the same point
        offer_word(boxes(trio(100, -100, 5), '0, trio(-20, 20, 0),
                         trio(100, -100, 5), '0, trio(20, -20, 0), 1'b0));
        offer_word(boxes(trio(-20000, -20000, -20000), trio(300, 300, 300),
                         trio(-500, 400, 90), trio(-20300, -20100, -19950),
                         trio(200, 200, 200), trio(600, -100, -80), 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check every word taken, then pick the stall for the next
    // edge. A requested hold-off is counted down here.
    // ------------------------------------------------------------------------
    initial
    begin
        int       hold_left;
        contact_t got;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.hit           = hit;
                got.push_axis     = push_axis;
                got.push_negative = push_negative;
                got.overlap_depth = overlap_depth;
                got.new_position  = new_position;
                got.new_velocity  = new_velocity;
                sb.check_contact(got);
            end
            if (rx_hold_req != 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !gapless && ($urandom_range(0, 99) < GAP_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no word moves on either side for too long
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("box_box_collision_resolve regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed pairs and a random burst at the reset
    // restitution, then a random burst per setting. The pipe is drained before every write.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [REST_BITS-1:0] settings[4];
        int                   phase;
        sb = new();
        settings[0] = '0;                          // no bounce beyond stopping
        settings[1] = REST_ONE;                    // fully elastic
        settings[2] = '1;                          // above one, must clamp
        settings[3] = REST_BITS'($urandom_range(1, 255));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        repeat (380) offer_word(random_pair());
        in_valid <= 1'b0;
        wait_drain();

        for (phase = 0; phase < 4; phase++)
        begin
            write_restitution(settings[phase]);
            // first setting: hold the receiver off long enough to fill the
            // pipe and push back on the sender
            if (phase == 0)
                rx_hold_req = LONG_HOLD;
            // second setting: run flat out on both sides
            gapless = (phase == 1);
            repeat (380) offer_word(random_pair());
            in_valid <= 1'b0;
            gapless = 1'b0;
            wait_drain();
        end

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("box_box_collision_resolve regression: pass");
        else
            $display("box_box_collision_resolve regression: fail");
        $finish;
    end

endmodule
